### rtl/bb3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_pkg: shared types and constants of the 3x3 box blur
// Widths, item structs, stage control struct and the reciprocal table.
// ----------------------------------------------------------------------------
package bb3_pkg;

  localparam int MAX_LINE    = 1024;
  localparam int COL_W       = $clog2(MAX_LINE);
  localparam int WIDTH_W     = 11;
  localparam int HEIGHT_W    = 16;
  localparam int CHAN_W      = 8;
  localparam int PIX_W       = 3 * CHAN_W;
  localparam int SUM_W       = 12;
  localparam int NUM_W       = SUM_W + 1;
  localparam int CNT_W       = 4;
  localparam int RECIP_W     = 20;
  localparam int RECIP_SHIFT = 20;
  localparam int PROD_W      = NUM_W + RECIP_W;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] in_red;
    logic [CHAN_W-1:0] in_green;
    logic [CHAN_W-1:0] in_blue;
    logic              is_flush;
  } pixel_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;
    logic              frame_end;
  } result_t;

  // Per-item control decided at accept time, carried down the pipe
  typedef struct packed {
    logic emit;
    logic last;
    logic top_ok;
    logic bot_ok;
    logic left_ok;
    logic right_ok;
  } ctl_t;

  // New right-hand window column: two line buffer rows and the incoming pixel
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } win_col_t;

  // Rounding numerators 2*sum+count per channel
  typedef struct packed {
    logic [NUM_W-1:0] n_red;
    logic [NUM_W-1:0] n_green;
    logic [NUM_W-1:0] n_blue;
    logic [CNT_W-1:0] count;
    logic             last;
  } sum_t;

  // ceil(2^RECIP_SHIFT / (2*count)); exact quotient for numerators below 2^13
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    case (count)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd262144;
      4'd3:    r = 20'd174763;
      4'd4:    r = 20'd131072;
      4'd6:    r = 20'd87382;
      4'd9:    r = 20'd58255;
      default: r = 20'd524288;
    endcase
    return r;
  endfunction

endpackage

### rtl/bb3_lines.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_lines: line buffer memory
// Holds the two rows above the input row, read-modify-write per column,
// with forwarding between back-to-back items on the same column.
// ----------------------------------------------------------------------------
module bb3_lines (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       adv,
  input  logic                       act,
  input  logic [bb3_pkg::COL_W-1:0]  col,
  input  logic [bb3_pkg::PIX_W-1:0]  pix,
  input  bb3_pkg::ctl_t              ctl,
  output logic                       col_valid,
  output bb3_pkg::win_col_t          new_col,
  output bb3_pkg::ctl_t              col_ctl
);

  // {upper, middle} per column
  logic [2*bb3_pkg::PIX_W-1:0] line_mem [bb3_pkg::MAX_LINE];

  logic [2*bb3_pkg::PIX_W-1:0] rd_data;
  logic                        s1_valid;
  logic [bb3_pkg::COL_W-1:0]   s1_col;
  logic [bb3_pkg::PIX_W-1:0]   s1_pix;
  bb3_pkg::ctl_t               s1_ctl;
  logic                        fwd;
  logic [bb3_pkg::PIX_W-1:0]   fwd_up;
  logic [bb3_pkg::PIX_W-1:0]   fwd_mid;
  logic [bb3_pkg::PIX_W-1:0]   up_eff;
  logic [bb3_pkg::PIX_W-1:0]   mid_eff;

  always_ff @(posedge clk) begin
    if (act) begin
      rd_data <= line_mem[col];
    end
  end

  // Shift the column down: middle becomes upper, the new pixel becomes middle
  always_ff @(posedge clk) begin
    if (s1_valid && adv) begin
      line_mem[s1_col] <= {mid_eff, s1_pix};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd      <= 1'b0;
    end else if (adv) begin
      s1_valid <= act;
      fwd      <= act && s1_valid && (col == s1_col);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_col  <= col;
      s1_pix  <= pix;
      s1_ctl  <= ctl;
      fwd_up  <= mid_eff;
      fwd_mid <= s1_pix;
    end
  end

  assign up_eff  = fwd ? fwd_up  : rd_data[2*bb3_pkg::PIX_W-1:bb3_pkg::PIX_W];
  assign mid_eff = fwd ? fwd_mid : rd_data[bb3_pkg::PIX_W-1:0];

  assign col_valid   = s1_valid;
  assign new_col.top = up_eff;
  assign new_col.mid = mid_eff;
  assign new_col.bot = s1_pix;
  assign col_ctl     = s1_ctl;

endmodule

### rtl/bb3_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_window: 3x3 window and masked neighborhood sums
// Shifts in one column per item, then sums the in-frame cells per channel.
// ----------------------------------------------------------------------------
module bb3_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              adv,
  input  logic              col_valid,
  input  bb3_pkg::win_col_t new_col,
  input  bb3_pkg::ctl_t     col_ctl,
  output logic              sum_valid,
  output bb3_pkg::sum_t     sum
);

  logic [bb3_pkg::PIX_W-1:0] cells [3][3];
  logic                      s2_valid;
  bb3_pkg::ctl_t             s2_ctl;
  bb3_pkg::sum_t             sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          cells[r][c] <= '0;
        end
      end
    end else if (adv && col_valid) begin
      for (int r = 0; r < 3; r++) begin
        cells[r][0] <= cells[r][1];
        cells[r][1] <= cells[r][2];
      end
      cells[0][2] <= new_col.top;
      cells[1][2] <= new_col.mid;
      cells[2][2] <= new_col.bot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid  <= 1'b0;
      sum_valid <= 1'b0;
    end else if (adv) begin
      s2_valid  <= col_valid && col_ctl.emit;
      sum_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ctl <= col_ctl;
      sum    <= sum_next;
    end
  end

  always_comb begin
    logic [2:0]               row_ok;
    logic [2:0]               col_ok;
    logic [8:0]               used;
    logic [bb3_pkg::SUM_W-1:0] s_red;
    logic [bb3_pkg::SUM_W-1:0] s_green;
    logic [bb3_pkg::SUM_W-1:0] s_blue;
    logic [bb3_pkg::CNT_W-1:0] cnt;
    row_ok  = {s2_ctl.bot_ok, 1'b1, s2_ctl.top_ok};
    col_ok  = {s2_ctl.right_ok, 1'b1, s2_ctl.left_ok};
    used    = '0;
    s_red   = '0;
    s_green = '0;
    s_blue  = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (row_ok[r] && col_ok[c]) begin
          used[3*r+c] = 1'b1;
          s_red   = s_red   + bb3_pkg::SUM_W'(cells[r][c][23:16]);
          s_green = s_green + bb3_pkg::SUM_W'(cells[r][c][15:8]);
          s_blue  = s_blue  + bb3_pkg::SUM_W'(cells[r][c][7:0]);
        end
      end
    end
    cnt              = bb3_pkg::CNT_W'($countones(used));
    sum_next.n_red   = {s_red,   1'b0} + bb3_pkg::NUM_W'(cnt);
    sum_next.n_green = {s_green, 1'b0} + bb3_pkg::NUM_W'(cnt);
    sum_next.n_blue  = {s_blue,  1'b0} + bb3_pkg::NUM_W'(cnt);
    sum_next.count   = cnt;
    sum_next.last    = s2_ctl.last;
  end

endmodule

### rtl/bb3_mean.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bb3_mean: rounded mean and result register
// Divides each numerator by 2*count through a reciprocal multiply.
// ----------------------------------------------------------------------------
module bb3_mean (
  input  logic             clk,
  input  logic             rst,
  input  logic             adv,
  input  logic             sum_valid,
  input  bb3_pkg::sum_t    sum,
  output logic             result_valid,
  output bb3_pkg::result_t result
);

  logic [bb3_pkg::RECIP_W-1:0] rcp;
  logic [bb3_pkg::PROD_W-1:0]  p_red;
  logic [bb3_pkg::PROD_W-1:0]  p_green;
  logic [bb3_pkg::PROD_W-1:0]  p_blue;

  assign rcp     = bb3_pkg::recip(sum.count);
  assign p_red   = bb3_pkg::PROD_W'(sum.n_red)   * bb3_pkg::PROD_W'(rcp);
  assign p_green = bb3_pkg::PROD_W'(sum.n_green) * bb3_pkg::PROD_W'(rcp);
  assign p_blue  = bb3_pkg::PROD_W'(sum.n_blue)  * bb3_pkg::PROD_W'(rcp);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.out_red   <= p_red[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
      result.out_green <= p_green[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
      result.out_blue  <= p_blue[bb3_pkg::RECIP_SHIFT +: bb3_pkg::CHAN_W];
      result.frame_end <= sum.last;
    end
  end

endmodule

### rtl/box_blur_3x3_edge_aware.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_aware: streaming 3x3 box blur with edge-aware divisor
// Pipeline: line buffer read register, window cells, sum register, result
//   register; results trail the pixel stream by frame_width+1 items.
// Throughput: one item per clock while no held result stalls the pipe, set
//   by one read and one write of the line buffer memory each cycle.
// Reset: synchronous; clears positions, window and pipeline valids, loads
//   frame_width = frame_height = 1024. Line buffers are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_aware (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            pixel_valid,
  output logic                            pixel_stall,
  input  bb3_pkg::pixel_t                 pixel,
  output logic                            result_valid,
  input  logic                            result_stall,
  output bb3_pkg::result_t                result,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data
);

  // Configuration registers
  logic [bb3_pkg::WIDTH_W-1:0]  frame_width;
  logic [bb3_pkg::HEIGHT_W-1:0] frame_height;

  // Stream positions
  logic [bb3_pkg::COL_W-1:0]    in_column, in_column_next;
  logic [bb3_pkg::HEIGHT_W-1:0] in_row, in_row_next;
  logic [bb3_pkg::COL_W-1:0]    out_column, out_column_next;
  logic [bb3_pkg::HEIGHT_W-1:0] out_row, out_row_next;

  logic [bb3_pkg::WIDTH_W-1:0]  eff_w;
  logic [bb3_pkg::HEIGHT_W-1:0] eff_h;
  logic                         adv;
  logic                         fire;
  logic                         past;
  logic                         act;
  logic [bb3_pkg::COL_W-1:0]    col;
  logic [bb3_pkg::WIDTH_W-1:0]  col_inc;
  logic [bb3_pkg::COL_W-1:0]    ocol;
  logic [bb3_pkg::WIDTH_W-1:0]  ocol_inc;
  logic [bb3_pkg::HEIGHT_W:0]   orow_inc;
  logic [bb3_pkg::PIX_W-1:0]    pix;
  bb3_pkg::ctl_t                ctl;

  logic                         col_valid;
  bb3_pkg::win_col_t            new_col;
  bb3_pkg::ctl_t                col_ctl;
  logic                         sum_valid;
  bb3_pkg::sum_t                sum;

  // --------------------------------------------------------------------------
  // Configuration: always ready, unchecked; to be written only while the stream is idle
  // --------------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= bb3_pkg::WIDTH_W'(1024);
      frame_height <= bb3_pkg::HEIGHT_W'(1024);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        bb3_pkg::CFG_FRAME_WIDTH:  frame_width  <= cfg_data[bb3_pkg::WIDTH_W-1:0];
        bb3_pkg::CFG_FRAME_HEIGHT: frame_height <= cfg_data[bb3_pkg::HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp width to 1..MAX_LINE, height to at least 1
  always_comb begin
    if (frame_width == '0) begin
      eff_w = bb3_pkg::WIDTH_W'(1);
    end else if (frame_width > bb3_pkg::WIDTH_W'(bb3_pkg::MAX_LINE)) begin
      eff_w = bb3_pkg::WIDTH_W'(bb3_pkg::MAX_LINE);
    end else begin
      eff_w = frame_width;
    end
  end

  assign eff_h = (frame_height == '0) ? bb3_pkg::HEIGHT_W'(1) : frame_height;

  // --------------------------------------------------------------------------
  // Handshake: the whole pipe advances unless the result register is held.
  // The stall is combinational from result_stall, so a new request is taken in
  // the same cycle a finished result is taken.
  // --------------------------------------------------------------------------
  assign adv         = !result_valid || !result_stall;
  assign pixel_stall = !adv;
  assign fire        = pixel_valid && adv;

  // A pixel after the last row acts as a flush; a flush inside the frame is
  // dropped with no effect at all.
  assign past = in_row >= eff_h;
  assign act  = fire && !(pixel.is_flush && !past);
  assign pix  = past ? '0 : {pixel.in_red, pixel.in_green, pixel.in_blue};

  // Input column, wrapped at the current width
  assign col     = ({1'b0, in_column} >= eff_w) ? '0 : in_column;
  assign col_inc = {1'b0, col} + bb3_pkg::WIDTH_W'(1);

  // Result position and which neighbors lie inside the frame
  assign ocol     = ({1'b0, out_column} >= eff_w) ? '0 : out_column;
  assign ocol_inc = {1'b0, ocol} + bb3_pkg::WIDTH_W'(1);
  assign orow_inc = {1'b0, out_row} + (bb3_pkg::HEIGHT_W + 1)'(1);

  always_comb begin
    ctl.emit     = (in_row >= bb3_pkg::HEIGHT_W'(2)) ||
                   ((in_row == bb3_pkg::HEIGHT_W'(1)) && (col != '0));
    ctl.top_ok   = out_row != '0;
    ctl.bot_ok   = orow_inc < {1'b0, eff_h};
    ctl.left_ok  = ocol != '0;
    ctl.right_ok = ocol_inc < eff_w;
    ctl.last     = (out_row >= eff_h) || (!ctl.bot_ok && !ctl.right_ok);
  end

  // Advance the positions; the frame's last result sends everything home
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    out_row_next    = out_row;
    if (act) begin
      if (col_inc >= eff_w) begin
        in_column_next = '0;
        if (in_row != '1) begin
          in_row_next = in_row + bb3_pkg::HEIGHT_W'(1);
        end
      end else begin
        in_column_next = col_inc[bb3_pkg::COL_W-1:0];
      end
      if (ctl.emit) begin
        if (ctl.last) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
          out_row_next    = '0;
        end else if (!ctl.right_ok) begin
          out_column_next = '0;
          out_row_next    = orow_inc[bb3_pkg::HEIGHT_W-1:0];
        end else begin
          out_column_next = ocol_inc[bb3_pkg::COL_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
      out_row    <= '0;
    end else begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
      out_row    <= out_row_next;
    end
  end

  // --------------------------------------------------------------------------
  // Datapath: line memory -> window and sums -> rounded mean / result register
  // --------------------------------------------------------------------------
  bb3_lines u_lines (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .act       (act),
    .col       (col),
    .pix       (pix),
    .ctl       (ctl),
    .col_valid (col_valid),
    .new_col   (new_col),
    .col_ctl   (col_ctl)
  );

  bb3_window u_window (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .col_valid (col_valid),
    .new_col   (new_col),
    .col_ctl   (col_ctl),
    .sum_valid (sum_valid),
    .sum       (sum)
  );

  bb3_mean u_mean (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .sum_valid    (sum_valid),
    .sum          (sum),
    .result_valid (result_valid),
    .result       (result)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The frame's last result returns all positions to the origin
  assert property (@(posedge clk) disable iff (rst)
    act && ctl.emit && ctl.last |=>
      (in_column == '0) && (in_row == '0) && (out_column == '0) && (out_row == '0))
    else $error("positions not cleared after frame end");

  // A dropped flush leaves the stream positions untouched
  assert property (@(posedge clk) disable iff (rst)
    fire && pixel.is_flush && !past |=>
      $stable(in_column) && $stable(in_row) && $stable(out_column) && $stable(out_row))
    else $error("dropped flush changed stream position");

  // A held result freezes the line and sum stages
  assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(sum_valid) && $stable(col_valid))
    else $error("pipeline moved while result was held");

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 edge-aware box blur
// Streams RGB pixel and flush requests through the blur, predicts every
// blurred pixel with a cycle-free software copy of the filter, and checks the
// results field by field under four idling patterns, a long receiver hold-off,
// a mid-frame drain and frame sizes from 1x1 up to a 160-pixel line.
// ----------------------------------------------------------------------------
module testbench;

  localparam int SETTLE_CYCLES = 8;        // pipeline is 4 deep
  localparam int HOLD_CYCLES   = 300;      // receiver hold-off length
  localparam int PHASE_ITEMS   = 370;      // minimum stream requests per idling phase
  localparam int WIDE_LINE     = 160;      // single wide row of the first phase
  localparam int TIMEOUT_NS    = 5000000;  // watchdog time, far above a slow run

  // Sender idle and receiver stall chances, in percent, per phase
  localparam int TX_IDLE  [4] = '{0, 76, 0, 15};
  localparam int RX_STALL [4] = '{0, 0, 76, 15};

  typedef enum logic {ROW_REG, ROW_PIXEL} plan_kind_t;

  // One row of the directed plan: a register write or a pixel request,
  // with an expected result typed in where it is obvious by eye
  typedef struct packed {
    plan_kind_t                          kind;
    logic [bb3_pkg::CFG_INDEX_W-1:0]     reg_idx;
    logic [bb3_pkg::CFG_DATA_W-1:0]      reg_val;
    bb3_pkg::pixel_t                     px;
    logic                                typed;
    bb3_pkg::result_t                    want;
  } plan_row_t;

  localparam int PLAN_ROWS = 22;
  localparam plan_row_t DIR_PLAN [PLAN_ROWS] = '{
    // 1x1 frame: the single pixel comes back unchanged, frame_end set
    '{ROW_REG,   bb3_pkg::CFG_FRAME_WIDTH,  16'd1, '0, 1'b0, '0},
    '{ROW_REG,   bb3_pkg::CFG_FRAME_HEIGHT, 16'd1, '0, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
      1'b1, '{8'd255, 8'd255, 8'd255, 1'b1}},
    // next 1x1 frame: a pixel offered after the frame is complete acts as flush
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd170, 8'd85, 8'd204, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1},
      1'b1, '{8'd0, 8'd0, 8'd0, 1'b1}},
    // flush at the start of a frame is dropped
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
    // 3x2 frame with extreme channels and rounding; a flush inside is dropped
    '{ROW_REG,   bb3_pkg::CFG_FRAME_WIDTH,  16'd3, '0, 1'b0, '0},
    '{ROW_REG,   bb3_pkg::CFG_FRAME_HEIGHT, 16'd2, '0, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd255, 8'd0, 8'd255, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd255, 8'd0, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd9, 8'd9, 8'd9, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd1, 8'd254, 8'd128, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd255, 8'd0, 8'd1, 1'b0}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0},
    '{ROW_PIXEL, bb3_pkg::CFG_FRAME_WIDTH,  16'd0, '{8'd0, 8'd0, 8'd0, 1'b1}, 1'b0, '0}
  };

  // DUT connections
  logic                            clk = 1'b0;
  logic                            rst;
  logic                            pixel_valid;
  logic                            pixel_stall;
  bb3_pkg::pixel_t                 pixel;
  logic                            result_valid;
  logic                            result_stall;
  bb3_pkg::result_t                result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [bb3_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data;

  // Typed expectation travels with the request it belongs to
  logic             typed_on;
  bb3_pkg::result_t typed_want;

  // Idling controls
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_on      = 1'b0;
  event hold_kick;

  // Blur predictor state
  logic [bb3_pkg::WIDTH_W-1:0]  width_reg;
  logic [bb3_pkg::HEIGHT_W-1:0] height_reg;
  logic [bb3_pkg::PIX_W-1:0]    buf_top [bb3_pkg::MAX_LINE];
  logic [bb3_pkg::PIX_W-1:0]    buf_mid [bb3_pkg::MAX_LINE];
  logic [bb3_pkg::PIX_W-1:0]    nbhd [3][3];
  int unsigned                  col_in, row_in, col_out, row_out;

  // Blurred pixels still owed by the DUT, oldest first
  bb3_pkg::result_t blur_due [$];

  int errors          = 0;
  int requests_taken  = 0;
  int requests_used   = 0;
  int results_checked = 0;
  int frame_ends      = 0;

  box_blur_3x3_edge_aware i_dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Blur predictor
  // --------------------------------------------------------------------------
  function automatic int unsigned width_used();
    if (width_reg == 0) return 1;
    if (width_reg > bb3_pkg::MAX_LINE) return bb3_pkg::MAX_LINE;
    return width_reg;
  endfunction

  function automatic int unsigned height_used();
    return (height_reg == 0) ? 1 : height_reg;
  endfunction

  function automatic void blur_clear();
    width_reg  = 11'd1024;
    height_reg = 16'd1024;
    for (int i = 0; i < bb3_pkg::MAX_LINE; i++) begin
      buf_top[i] = '0;
      buf_mid[i] = '0;
    end
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) nbhd[r][c] = '0;
    end
    col_in  = 0;
    row_in  = 0;
    col_out = 0;
    row_out = 0;
  endfunction

  // Advance the filter by one accepted request; return 1 with the blurred
  // pixel in res when the request releases a result
  function automatic bit blur_step(input bb3_pkg::pixel_t item,
                                   output bb3_pkg::result_t res);
    int unsigned w, h, col, cnt;
    int unsigned sum [3];
    logic [bb3_pkg::PIX_W-1:0] px, pel;
    bit past, emit, last;
    res  = '0;
    w    = width_used();
    h    = height_used();
    past = row_in >= h;
    // drop a flush while the frame still wants pixels
    if (item.is_flush && !past) return 1'b0;
    px = past ? '0 : {item.in_red, item.in_green, item.in_blue};
    if (col_in >= w) col_in = 0;
    col  = col_in;
    emit = (row_in >= 2) || (row_in == 1 && col >= 1);
    // shift the window left, load the new right-hand column
    for (int r = 0; r < 3; r++) begin
      nbhd[r][0] = nbhd[r][1];
      nbhd[r][1] = nbhd[r][2];
    end
    nbhd[0][2]   = buf_top[col];
    nbhd[1][2]   = buf_mid[col];
    nbhd[2][2]   = px;
    buf_top[col] = buf_mid[col];
    buf_mid[col] = px;
    col_in = col + 1;
    if (col_in >= w) begin
      col_in = 0;
      if (row_in < 16'hFFFF) row_in++;
    end
    if (!emit) return 1'b0;
    if (col_out >= w) col_out = 0;
    sum = '{0, 0, 0};
    cnt = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        // count only neighbors inside the frame
        if (!((r == 0 && row_out < 1) || (r == 2 && row_out + 1 >= h) ||
              (c == 0 && col_out < 1) || (c == 2 && col_out + 1 >= w))) begin
          pel = nbhd[r][c];
          sum[0] += pel[23:16];
          sum[1] += pel[15:8];
          sum[2] += pel[7:0];
          cnt++;
        end
      end
    end
    if (cnt == 0) cnt = 1;
    // round half up: floor((2*sum + n) / (2*n))
    res.out_red   = 8'((2 * sum[0] + cnt) / (2 * cnt));
    res.out_green = 8'((2 * sum[1] + cnt) / (2 * cnt));
    res.out_blue  = 8'((2 * sum[2] + cnt) / (2 * cnt));
    last = (row_out >= h) || (row_out + 1 >= h && col_out + 1 >= w);
    res.frame_end = last;
    if (last) begin
      col_in  = 0;
      row_in  = 0;
      col_out = 0;
      row_out = 0;
    end else begin
      col_out++;
      if (col_out >= w) begin
        col_out = 0;
        row_out++;
      end
    end
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: predict at every accepted pixel or flush request
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : take_side
    bb3_pkg::result_t blurred;
    bit               owed;
    if (!rst && pixel_valid && !pixel_stall) begin
      requests_taken++;
      // flushes inside the frame are dropped and do not count as stream traffic
      if (!(pixel.is_flush && row_in < height_used())) requests_used++;
      owed = blur_step(pixel, blurred);
      if (owed || typed_on) blur_due.push_back(typed_on ? typed_want : blurred);
    end
  end

  // --------------------------------------------------------------------------
  // Result side: random stall, plus a long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    result_stall <= hold_on || (rx_stall_pct != 0 && $urandom_range(99) < rx_stall_pct);
  end

  // Count the hold-off in clock edges of its own
  initial begin
    forever begin
      @(hold_kick);
      @(posedge clk);
      hold_on = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_on = 1'b0;
    end
  end

  // Compare each accepted result with the oldest blurred pixel owed
  always @(posedge clk) begin : give_side
    bb3_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (blur_due.size() == 0) begin
        $error("result with nothing owed: %p", result);
        errors++;
      end else begin
        want = blur_due.pop_front();
        results_checked++;
        if (result.frame_end) frame_ends++;
        if (result.out_red !== want.out_red) begin
          $error("out_red: expected %0d, got %0d", want.out_red, result.out_red);
          errors++;
        end
        if (result.out_green !== want.out_green) begin
          $error("out_green: expected %0d, got %0d", want.out_green, result.out_green);
          errors++;
        end
        if (result.out_blue !== want.out_blue) begin
          $error("out_blue: expected %0d, got %0d", want.out_blue, result.out_blue);
          errors++;
        end
        if (result.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0d, got %0d", want.frame_end, result.frame_end);
          errors++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers (all called at a falling edge, return at a falling edge)
  // --------------------------------------------------------------------------

  // Bias channels toward the extremes now and then
  function automatic logic [bb3_pkg::CHAN_W-1:0] pick_chan();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return bb3_pkg::CHAN_W'($urandom_range(255));
    endcase
  endfunction

  function automatic bb3_pkg::pixel_t pick_pixel(input bit flush);
    bb3_pkg::pixel_t p;
    p.in_red   = pick_chan();
    p.in_green = pick_chan();
    p.in_blue  = pick_chan();
    p.is_flush = flush;
    return p;
  endfunction

  // Offer one request, hold it through stalls, then idle at random
  task automatic send_request(input bb3_pkg::pixel_t p, input bit typed = 1'b0,
                              input bb3_pkg::result_t want = '0);
    pixel_valid <= 1'b1;
    pixel       <= p;
    typed_on    <= typed;
    typed_want  <= want;
    @(posedge clk);
    while (pixel_stall) @(posedge clk);
    @(negedge clk);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
  endtask

  // Drop valid and wait until every owed result is out and the pipe is empty
  task automatic drain_results();
    pixel_valid <= 1'b0;
    @(negedge clk);
    while (blur_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [bb3_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [bb3_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == bb3_pkg::CFG_FRAME_WIDTH) width_reg = val[bb3_pkg::WIDTH_W-1:0];
    else height_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Feed pixels then flushes until the stream sits at a frame boundary
  task automatic close_frame();
    while (row_in != 0 || col_in != 0) send_request(pick_pixel(row_in >= height_used()));
  endtask

  // Change the frame size only at a frame boundary with the block idle
  task automatic set_frame(input int unsigned w, input int unsigned h);
    close_frame();
    drain_results();
    write_reg(bb3_pkg::CFG_FRAME_WIDTH, bb3_pkg::CFG_DATA_W'(w));
    write_reg(bb3_pkg::CFG_FRAME_HEIGHT, bb3_pkg::CFG_DATA_W'(h));
  endtask

  // One frame of random pixels with some noise: stray flushes inside the
  // frame, pixels among the trailing flushes, now and then a cut-short tail and a drain
  task automatic stream_frame(input int unsigned w, input int unsigned h);
    int unsigned tail;
    for (int unsigned i = 0; i < w * h; i++) begin
      if ($urandom_range(99) < 3) send_request(pick_pixel(1'b1));
      if ($urandom_range(299) == 0) drain_results();
      send_request(pick_pixel(1'b0));
    end
    tail = w + 1;
    if ($urandom_range(99) < 8) tail = $urandom_range(w);
    for (int unsigned j = 0; j < tail; j++) send_request(pick_pixel($urandom_range(99) >= 15));
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main_seq
    int unsigned w, h, start;
    rst          = 1'b1;
    pixel_valid  = 1'b0;
    pixel        = '0;
    result_stall = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = bb3_pkg::CFG_FRAME_WIDTH;
    cfg_data     = '0;
    typed_on     = 1'b0;
    typed_want   = '0;
    blur_clear();
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed plan: registers only written with the block drained
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (DIR_PLAN[i].kind == ROW_REG) begin
        drain_results();
        write_reg(DIR_PLAN[i].reg_idx, DIR_PLAN[i].reg_val);
      end else begin
        send_request(DIR_PLAN[i].px, DIR_PLAN[i].typed, DIR_PLAN[i].want);
      end
    end

    // Random phases, one per idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = TX_IDLE[ph];
      rx_stall_pct = RX_STALL[ph];
      start        = requests_used;
      if (ph == 0) begin
        // wide line, single row
        set_frame(WIDE_LINE, 1);
        stream_frame(WIDE_LINE, 1);
        // hold the receiver off while the sender keeps offering: fill the pipe
        set_frame(4, 8);
        -> hold_kick;
        stream_frame(4, 8);
      end
      if (ph == 3) begin
        // tallest frame, cut short by lowering the height below the current row
        set_frame(2, 16'hFFFF);
        repeat (24) send_request(pick_pixel(1'b0));
        drain_results();
        write_reg(bb3_pkg::CFG_FRAME_HEIGHT, 16'd5);
      end
      while (requests_used - start < PHASE_ITEMS) begin
        case ($urandom_range(9))
          0:       w = 1;
          1:       w = $urandom_range(21, 64);
          default: w = $urandom_range(2, 12);
        endcase
        case ($urandom_range(7))
          0:       h = 1;
          1:       h = $urandom_range(7, 12);
          default: h = $urandom_range(2, 6);
        endcase
        if (w > 20) h = $urandom_range(1, 3);
        set_frame(w, h);
        stream_frame(w, h);
      end
      close_frame();
    end

    drain_results();
    $display("Covered %0d requests (%0d fed the stream), %0d results checked, %0d frame ends;",
             requests_taken, requests_used, results_checked, frame_ends);
    $display("frames from 1x1 to a 160-pixel line and the tallest height, four idling patterns.");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #TIMEOUT_NS;
    $display("FAILURE");
    $finish;
  end

endmodule

### box_blur_3x3_edge_aware.f
rtl/bb3_pkg.sv
rtl/bb3_lines.sv
rtl/bb3_window.sv
rtl/bb3_mean.sv
rtl/box_blur_3x3_edge_aware.sv
bench/testbench.sv
